// File: rtl/bpfa_pkg.sv
// Types, codes and default sizes shared by the bitmap page frame allocator.
`default_nettype none

package bpfa_pkg;

   localparam int NUM_PAGES_DEF  = 4096;
   localparam int PAGE_BYTES_DEF = 4096;

   localparam logic [12:0] LIMIT_RESET = 13'd4096;
   localparam logic [12:0] COUNT_MAX   = 13'h1FFF;

   localparam logic [1:0] REQ_ALLOC        = 2'd0;
   localparam logic [1:0] REQ_FREE         = 2'd1;
   localparam logic [1:0] REQ_ALLOC_REGION = 2'd2;
   localparam logic [1:0] REQ_FREE_REGION  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] addr;
      logic [31:0] region_size;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] page_addr;
      logic [12:0] used_pages;
   } rsp_word_type;

   typedef enum logic [1:0] {
      UPD_ALLOC = 2'd0,
      UPD_SET   = 2'd1,
      UPD_CLEAR = 2'd2
   } upd_op_type;

   typedef struct packed {
      logic [31:0] word;
      logic [5:0]  flips;
      logic        found;
      logic [4:0]  bit_idx;
   } upd_result_type;

endpackage

`default_nettype wire

// File: rtl/bpfa_map_ram.sv
// Bitmap memory: one write port and one registered read port.
`default_nettype none

module bpfa_map_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] map_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bpfa_word_update.sv
// Word modifier: sets, clears or allocates bits of one bitmap word and counts the flips.
`default_nettype none

module bpfa_word_update (
   input  wire logic                 [31:0] old_word,
   input  wire logic                 [31:0] mask,
   input  wire bpfa_pkg::upd_op_type        op,
   output bpfa_pkg::upd_result_type         result
);

   logic [31:0] free_bits;
   logic [31:0] lowest;
   logic [31:0] new_word;
   logic [31:0] flipped;
   logic [4:0]  bit_idx;

   function automatic logic [5:0] popcount(input logic [31:0] v);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) begin
         l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
      end
      for (int i = 0; i < 8; i++) begin
         l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
      end
      for (int i = 0; i < 4; i++) begin
         l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
      end
      return 6'(l4[0]) + 6'(l4[1]);
   endfunction

   assign free_bits = mask & ~old_word;
   assign lowest    = free_bits & (~free_bits + 32'd1);

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < 32; b++) begin
         if (lowest[b]) begin
            bit_idx = bit_idx | 5'(b);
         end
      end
   end

   always_comb begin
      unique case (op)
         bpfa_pkg::UPD_ALLOC: begin
            new_word = old_word | lowest;
            flipped  = lowest;
         end
         bpfa_pkg::UPD_SET: begin
            new_word = old_word | mask;
            flipped  = mask & ~old_word;
         end
         bpfa_pkg::UPD_CLEAR: begin
            new_word = old_word & ~mask;
            flipped  = mask & old_word;
         end
         default: begin
            new_word = old_word;
            flipped  = '0;
         end
      endcase
   end

   assign result.word    = new_word;
   assign result.flips   = popcount(flipped);
   assign result.found   = (op == bpfa_pkg::UPD_ALLOC) && (|lowest);
   assign result.bit_idx = bit_idx;

endmodule

`default_nettype wire

// File: rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator: request sequencer, bitmap memory and count.
`default_nettype none

// The bitmap lives in a memory of ceil(NUM_PAGES/32) words of 32 bits, and every request
// that touches the bitmap is handled as a read, modify and write-back of one word at a time.
// Allocate-one scans the words up to the active limit until it finds a free page, free-one
// touches one bitmap word, and a region touches each bitmap word it covers. A request that
// needs no bitmap access goes straight to its response. One request is worked on at a time,
// and the next is taken while the previous response still waits. After reset a clearing
// pass writes the whole bitmap, during which no request is taken; the limit register can be
// written at any time and is always ready.

module bitmap_page_frame_allocator #(
   parameter int NUM_PAGES  = bpfa_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bpfa_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bpfa_pkg::rsp_word_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [12:0]            csr_data
);

   localparam int PB_SH     = $clog2(PAGE_BYTES);
   localparam int PW_RAW    = $clog2(NUM_PAGES);
   localparam int PW        = (PW_RAW < 6) ? 6 : PW_RAW;
   localparam int WW        = PW - 5;
   localparam int MAP_WORDS = (NUM_PAGES + 31) / 32;
   localparam int LW        = PW + 1;
   localparam int CW        = (LW > 13) ? LW : 13;
   localparam int QW        = 32 - PB_SH;
   localparam int EW        = QW + 1;
   localparam int XW        = (EW > LW) ? EW : LW;
   localparam int BW        = PW + PB_SH;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SETUP  = 6'b000100,
      S_READ   = 6'b001000,
      S_MODIFY = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [12:0]            csr_ff, csr_in;
   logic [12:0]            count_ff, count_in;
   logic [1:0]             req_type_ff, req_type_in;
   logic [QW-1:0]          start_ff, start_in;
   logic [EW-1:0]          end_ff, end_in;
   logic                   addr_zero_ff, addr_zero_in;
   bpfa_pkg::upd_op_type   op_ff, op_in;
   logic [WW-1:0]          word_ff, word_in;
   logic [WW-1:0]          first_word_ff, first_word_in;
   logic [WW-1:0]          last_word_ff, last_word_in;
   logic [4:0]             lo_ff, lo_in;
   logic [4:0]             hi_ff, hi_in;
   logic [1:0]             status_ff, status_in;
   logic [23:0]            paddr_ff, paddr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bpfa_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic [CW-1:0]          lim_c;
   logic [LW-1:0]          lim;
   logic [LW-1:0]          lim_m1;
   logic [XW-1:0]          start_x;
   logic [XW-1:0]          end_x;
   logic [XW-1:0]          lim_x;
   logic [XW-1:0]          endc_x;
   logic [XW-1:0]          last_pg_x;
   logic                   over;
   logic [31:0]            req_size;
   logic [4:0]             lo_eff;
   logic [4:0]             hi_eff;
   logic [31:0]            word_mask;
   logic [PW-1:0]          page;
   logic [BW-1:0]          byte_addr;
   logic [13:0]            count_sum;
   logic                   wr_en;
   logic [31:0]            wr_data;
   logic                   rd_en;
   logic [31:0]            rd_data;
   bpfa_pkg::upd_result_type upd;

   bpfa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (WW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   bpfa_word_update u_update (
      .old_word (rd_data),
      .mask     (word_mask),
      .op       (op_ff),
      .result   (upd)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_in     = csr_valid ? csr_data : csr_ff;

   assign lim_c  = (CW'(csr_ff) > CW'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(csr_ff);
   assign lim    = LW'(lim_c);
   assign lim_m1 = lim - LW'(1);

   assign start_x   = XW'(start_ff);
   assign end_x     = XW'(end_ff);
   assign lim_x     = XW'(lim);
   assign over      = end_x > lim_x;
   assign endc_x    = over ? lim_x : end_x;
   assign last_pg_x = endc_x - XW'(1);

   assign req_size  = (req_data.req_type == bpfa_pkg::REQ_FREE) ? 32'd0 : req_data.region_size;

   assign lo_eff    = (word_ff == first_word_ff) ? lo_ff : 5'd0;
   assign hi_eff    = (word_ff == last_word_ff) ? hi_ff : 5'd31;
   assign word_mask = ({32{1'b1}} << lo_eff) & ({32{1'b1}} >> (5'd31 - hi_eff));

   assign page      = {word_ff, upd.bit_idx};
   assign byte_addr = BW'(page) << PB_SH;
   assign count_sum = 14'(count_ff) + 14'(upd.flips);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      req_type_in   = req_type_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      addr_zero_in  = addr_zero_ff;
      op_in         = op_ff;
      word_in       = word_ff;
      first_word_in = first_word_ff;
      last_word_in  = last_word_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      status_in     = status_ff;
      paddr_in      = paddr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_data       = upd.word;
      rd_en         = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            if (word_ff == WW'(MAP_WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WW'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               req_type_in  = req_data.req_type;
               start_in     = req_data.addr[31:PB_SH];
               end_in       = EW'(req_data.addr[31:PB_SH]) + EW'(req_size[31:PB_SH]) + EW'(1);
               addr_zero_in = (req_data.addr == 32'd0);
               state_in     = S_SETUP;
            end
         end
         S_SETUP: begin
            paddr_in = '0;
            if (req_type_ff == bpfa_pkg::REQ_ALLOC) begin
               if (CW'(count_ff) >= CW'(lim)) begin
                  status_in = bpfa_pkg::ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  status_in     = bpfa_pkg::ST_NO_FREE;
                  op_in         = bpfa_pkg::UPD_ALLOC;
                  word_in       = '0;
                  first_word_in = '0;
                  last_word_in  = lim_m1[PW-1:5];
                  lo_in         = 5'd0;
                  hi_in         = lim_m1[4:0];
                  state_in      = S_READ;
               end
            end else if (req_type_ff == bpfa_pkg::REQ_FREE && addr_zero_ff) begin
               status_in = bpfa_pkg::ST_OK;
               state_in  = S_DONE;
            end else begin
               status_in = over ? bpfa_pkg::ST_RANGE : bpfa_pkg::ST_OK;
               op_in     = (req_type_ff == bpfa_pkg::REQ_ALLOC_REGION) ?
                           bpfa_pkg::UPD_SET : bpfa_pkg::UPD_CLEAR;
               if (start_x >= endc_x) begin
                  state_in = S_DONE;
               end else begin
                  word_in       = start_x[PW-1:5];
                  first_word_in = start_x[PW-1:5];
                  last_word_in  = last_pg_x[PW-1:5];
                  lo_in         = start_x[4:0];
                  hi_in         = last_pg_x[4:0];
                  state_in      = S_READ;
               end
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            wr_en = 1'b1;
            if (op_ff == bpfa_pkg::UPD_CLEAR) begin
               count_in = (count_ff >= 13'(upd.flips)) ? count_ff - 13'(upd.flips) : 13'd0;
            end else begin
               count_in = (count_sum > 14'(bpfa_pkg::COUNT_MAX)) ?
                          bpfa_pkg::COUNT_MAX : 13'(count_sum);
            end
            if (upd.found) begin
               status_in = bpfa_pkg::ST_OK;
               paddr_in  = 24'(byte_addr);
               state_in  = S_DONE;
            end else if (word_ff == last_word_ff) begin
               state_in = S_DONE;
            end else begin
               word_in  = word_ff + WW'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.page_addr  = paddr_ff;
               rsp_data_in.used_pages = count_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         csr_ff       <= bpfa_pkg::LIMIT_RESET;
         count_ff     <= '0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         count_ff     <= count_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      addr_zero_ff  <= addr_zero_in;
      op_ff         <= op_in;
      first_word_ff <= first_word_in;
      last_word_ff  <= last_word_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      status_ff     <= status_in;
      paddr_ff      <= paddr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("A request could be taken during the clearing pass.");

   a_response_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("A response appeared without a finished request.");

   a_alloc_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY && upd.found) |-> (LW'(page) < lim))
      else $error("An allocated page lies at or above the active limit.");

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) |-> $past(state_ff == S_READ))
      else $error("A bitmap word was written back without being read first.");

endmodule

`default_nettype wire
